@@ hdl/ancl_pkg.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup: shared package
// Types, constants and helper functions used by the front end, the command
// queue and the table back end of the archive name lookup block.
// ----------------------------------------------------------------------------
package ancl_pkg;

  // Table geometry. The count must be able to hold the depth itself.
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Command queue between front end and back end; depth is a power of two so
  // that the pointers wrap naturally.
  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // CRC-32 (IEEE, reflected).
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // ASCII case folding.
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Operation codes of an input item, also used for queued commands.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_NAME   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  name_char;
    logic        char_present;
    logic        name_last;
    logic [31:0] key_in;
    logic [31:0] length_in;
    logic [31:0] position_in;
    logic [15:0] label_in;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] name_key;
    logic [31:0] length_out;
    logic [31:0] position_out;
    logic [15:0] label_out;
    logic        table_overflow;
  } out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] length;
    logic [31:0] position;
    logic [15:0] label;
  } entry_t;

  // A command as it travels from the front end to the back end. For a lookup
  // the target holds the finalised CRC; for an append the entry is valid.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] target;
    entry_t      entry;
  } cmd_t;

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
      res = ch - CASE_OFFSET;
    end
    return res;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/archive_name_crc_lookup.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup
// Keyed entry table with CRC-32 filename hashing and binary search lookup.
// ----------------------------------------------------------------------------
// Usage. Items enter through a queue-style port: an item transfers on a
// rising edge with push high and full low. Opcode clear empties the table
// and the overflow flag, append stores one entry (entries must arrive in
// ascending key order), and a filename byte is uppercased and folded into
// the running CRC-32. The byte marked last finalises the CRC and queues a
// lookup. Results leave through a second queue-style port: the oldest result
// is shown while empty is low and transfers on an edge with pop high.
// Throughput: filename bytes transfer one per cycle while full is low. The
// back end executes clears and appends from its idle state. A lookup steps
// through probes of the entry memory, whose read port is registered: an
// address state picks the probe and a compare state checks the entry read,
// until a match or an empty window ends it. A four-deep command queue lets
// the input side carry on while the back end searches.
// Reset empties both queues, clears the entry count and overflow flag and
// sets the CRC to all ones; the table memory itself is not cleared. While a
// result is not popped, the back end executes clears and appends ahead of
// the next lookup and holds it and all behind it; a full queue raises full.
// ----------------------------------------------------------------------------
module archive_name_crc_lookup (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  ancl_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output ancl_pkg::out_t out_o
);

  ancl_pkg::cmd_t front_cmd, queue_cmd;
  logic           front_push;
  logic           queue_full, queue_empty, queue_pop;

  // Front end: CRC accumulation and command classification.
  ancl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmdq_full_i (queue_full),
    .cmd_push_o  (front_push),
    .cmd_o       (front_cmd)
  );

  // Decoupling queue so that bytes keep streaming during a search.
  ancl_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  // Back end: table storage, search sequencer and the result register.
  ancl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (queue_empty),
    .cmd_pop_o   (queue_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

@@ hdl/ancl_front.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup: front end
// Accepts input items, folds filename bytes into the running CRC and turns
// clears, appends and completed names into commands for the back end.
// ----------------------------------------------------------------------------
module ancl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  ancl_pkg::in_t  in_i,
  input  logic           cmdq_full_i,
  output logic           cmd_push_o,
  output ancl_pkg::cmd_t cmd_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_next;
  logic        accept;

  assign full   = cmdq_full_i;
  assign accept = push && !cmdq_full_i;

  // An absent character leaves the CRC untouched, which permits empty names.
  assign crc_next = in_i.char_present ?
                    ancl_pkg::crc_byte(crc_q, ancl_pkg::to_upper(in_i.name_char)) : crc_q;

  always_comb begin
    crc_d            = crc_q;
    cmd_push_o       = 1'b0;
    cmd_o.op         = in_i.opcode;
    cmd_o.target     = ~crc_next;
    cmd_o.entry      = '{key: in_i.key_in, length: in_i.length_in,
                         position: in_i.position_in, label: in_i.label_in};
    if (accept) begin
      unique case (in_i.opcode)
        ancl_pkg::OP_CLEAR,
        ancl_pkg::OP_APPEND: begin
          cmd_push_o = 1'b1;
        end
        ancl_pkg::OP_NAME: begin
          if (in_i.name_last) begin
            cmd_push_o = 1'b1;
            crc_d      = ancl_pkg::CRC_ONES;
          end else begin
            crc_d      = crc_next;
          end
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= ancl_pkg::CRC_ONES;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

@@ hdl/ancl_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup: command queue
// A short first-in first-out queue that decouples the front end from the
// table back end.
// ----------------------------------------------------------------------------
module ancl_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ancl_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ancl_pkg::cmd_t data_o,
  output logic           empty_o
);

  ancl_pkg::cmd_t                     slots_q [ancl_pkg::CMDQ_DEPTH];
  logic [ancl_pkg::CMDQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ancl_pkg::CMDQ_CNT_W-1:0]    count_q;
  logic                               do_push, do_pop;

  assign full_o  = (count_q == ancl_pkg::CMDQ_CNT_W'(ancl_pkg::CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ancl_back.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup: table back end
// Holds the entry table, executes clears and appends, runs the binary
// search for lookups and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ancl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ancl_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output ancl_pkg::out_t out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  ancl_pkg::entry_t table_mem [ancl_pkg::TABLE_DEPTH];
  ancl_pkg::entry_t rd_q;

  logic [1:0]                 state_q, state_d;
  logic [ancl_pkg::CNT_W-1:0] count_q, count_d;
  logic                       ovf_q, ovf_d;
  // Search window [lo, hi) with an exclusive upper bound.
  logic [ancl_pkg::CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [ancl_pkg::CNT_W-1:0] mid;
  logic [31:0]                target_q, target_d;
  logic                       out_valid_q, out_valid_d;
  ancl_pkg::out_t             out_q, out_d;
  logic                       mem_we;

  // Same probe as lo + (hi_incl - lo) / 2 with hi_incl = hi - 1.
  assign mid = lo_q + ((hi_q - 1'b1 - lo_q) >> 1);

  assign empty = !out_valid_q;
  assign out_o = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    target_d    = target_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            ancl_pkg::OP_CLEAR: begin
              cmd_pop_o = 1'b1;
              count_d   = '0;
              ovf_d     = 1'b0;
            end
            ancl_pkg::OP_APPEND: begin
              cmd_pop_o = 1'b1;
              if (count_q < ancl_pkg::CNT_W'(ancl_pkg::TABLE_DEPTH)) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                ovf_d   = 1'b1;
              end
            end
            default: begin
              // A lookup starts only once the result slot is free.
              if (!out_valid_q) begin
                cmd_pop_o = 1'b1;
                lo_d      = '0;
                hi_d      = count_q;
                target_d  = cmd_i.target;
                state_d   = S_ADDR;
              end
            end
          endcase
        end
      end
      S_ADDR: begin
        if (lo_q >= hi_q) begin
          out_d       = '{found: 1'b0, name_key: target_q, length_out: '0,
                          position_out: '0, label_out: '0, table_overflow: ovf_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mid_d   = mid;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_q.key == target_q) begin
          out_d       = '{found: 1'b1, name_key: target_q, length_out: rd_q.length,
                          position_out: rd_q.position, label_out: rd_q.label,
                          table_overflow: ovf_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (rd_q.key < target_q) begin
          lo_d    = mid_q + 1'b1;
          state_d = S_ADDR;
        end else begin
          hi_d    = mid_q;
          state_d = S_ADDR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Entry table: one write port for appends, one registered read port for
  // the search probes.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[ancl_pkg::IDX_W-1:0]] <= cmd_i.entry;
    end
    rd_q <= table_mem[mid[ancl_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    target_q <= target_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/ancl_checker.sv @@
// ----------------------------------------------------------------------------
// Archive name CRC lookup: port checker
// Concurrent assertions on the ports of the lookup block, bound to the top
// level.
// ----------------------------------------------------------------------------
module ancl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           push,
  input logic           full,
  input ancl_pkg::in_t  in_i,
  input logic           empty,
  input logic           pop,
  input ancl_pkg::out_t out_o
);

  // A waiting result stays put until it is popped.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("result changed or vanished before pop");

  // A miss carries zero payload.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.found) |->
      (out_o.length_out == '0 && out_o.position_out == '0 && out_o.label_out == '0))
    else $error("miss with non-zero payload");

  // Only one lookup result is in flight, so after a pop the port is empty in
  // the next cycle.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |=> empty)
    else $error("new result appeared directly after a pop");

  // A result on show is built only from written entries and the finalised
  // CRC, so every bit of it is defined.
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty) |-> !$isunknown(out_o))
    else $error("result shown with undefined bits");

endmodule

bind archive_name_crc_lookup ancl_checker u_ancl_checker (.*);
